FILE: src/ssd_pkg.sv
// Package: shared widths, status codes and payload types for the signed divider.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

	localparam int DATA_WIDTH         = 32;
	localparam int DIV_BITS_PER_STAGE = 1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] dividend;
		logic signed [DATA_WIDTH-1:0] divisor;
	} ssd_req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quotient;
		logic        [DATA_WIDTH-2:0] remainder_magnitude;
		logic        [1:0]            status;
	} ssd_rsp_t;

	// In-flight division: operand magnitudes, partial remainder, quotient so far.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] amag;
		logic [DATA_WIDTH-1:0] bmag;
		logic [DATA_WIDTH-2:0] rem;
		logic [DATA_WIDTH-1:0] quo;
		logic                  negative;
		logic                  div_zero;
	} ssd_work_t;

endpackage
`default_nettype wire

FILE: src/ssd_prep.sv
// Input stage: operand magnitudes, sign of the result and divide-by-zero detect.
`timescale 1ns / 1ps
`default_nettype none
module ssd_prep (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  ssd_pkg::ssd_req_t   req,
	output logic                valid_s1,
	output ssd_pkg::ssd_work_t  data_s1
);
	import ssd_pkg::*;

	logic [DATA_WIDTH-1:0] a_raw;
	logic [DATA_WIDTH-1:0] b_raw;
	ssd_work_t             work;

	assign a_raw = req.dividend;
	assign b_raw = req.divisor;

	always_comb begin
		work.amag     = a_raw[DATA_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
		work.bmag     = b_raw[DATA_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
		work.rem      = '0;
		work.quo      = '0;
		work.negative = a_raw[DATA_WIDTH-1] ^ b_raw[DATA_WIDTH-1];
		work.div_zero = (b_raw == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= work;
		end
	end

endmodule
`default_nettype wire

FILE: src/ssd_step.sv
// Divider stage: restoring shift-subtract over a fixed slice of quotient bits.
`timescale 1ns / 1ps
`default_nettype none
module ssd_step #(
	parameter int FIRST_BIT  = 31,
	parameter int STAGE_BITS = 1
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  ssd_pkg::ssd_work_t  in_data,
	output logic                valid_s1,
	output ssd_pkg::ssd_work_t  data_s1
);
	import ssd_pkg::*;

	// abits[j] is the dividend bit brought down at step j of this slice
	logic [STAGE_BITS-1:0] abits;

	for (genvar j = 0; j < STAGE_BITS; j++) begin : g_bit
		assign abits[j] = in_data.amag[FIRST_BIT - j];
	end

	logic [DATA_WIDTH-1:0] trial;
	logic [DATA_WIDTH-1:0] diff;
	ssd_work_t             work;

	always_comb begin
		work = in_data;
		trial = '0;
		diff = '0;
		for (int j = 0; j < STAGE_BITS; j++) begin
			trial = {work.rem, abits[j]};
			diff  = trial - work.bmag;
			if (trial >= work.bmag) begin
				work.rem = diff[DATA_WIDTH-2:0];
				work.quo = {work.quo[DATA_WIDTH-2:0], 1'b1};
			end else begin
				work.rem = trial[DATA_WIDTH-2:0];
				work.quo = {work.quo[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= work;
		end
	end

endmodule
`default_nettype wire

FILE: src/ssd_post.sv
// Output stage: sign fix-up, overflow saturation and divide-by-zero result.
`timescale 1ns / 1ps
`default_nettype none
module ssd_post (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  ssd_pkg::ssd_work_t  in_data,
	output logic                valid_s1,
	output ssd_pkg::ssd_rsp_t   rsp_s1
);
	import ssd_pkg::*;

	localparam logic [DATA_WIDTH-1:0] POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	ssd_rsp_t rsp;

	always_comb begin
		priority if (in_data.div_zero) begin
			rsp.quotient            = '0;
			rsp.remainder_magnitude = in_data.amag[DATA_WIDTH-1] ? '1
			                          : in_data.amag[DATA_WIDTH-2:0];
			rsp.status              = STATUS_DIV_ZERO;
		end else if (!in_data.negative && in_data.quo[DATA_WIDTH-1]) begin
			// only the most negative value over minus one lands here
			rsp.quotient            = POS_MAX;
			rsp.remainder_magnitude = in_data.rem;
			rsp.status              = STATUS_OVERFLOW;
		end else begin
			rsp.quotient            = in_data.negative ? (~in_data.quo + 1'b1) : in_data.quo;
			rsp.remainder_magnitude = in_data.rem;
			rsp.status              = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			rsp_s1 <= rsp;
		end
	end

endmodule
`default_nettype wire

FILE: src/signed_shift_subtract_divider_unit.sv
// Top level: fully pipelined signed restoring divider.
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Request: drive req (dividend, divisor) and pulse start; a request is taken
//   at every rising edge with start high and busy low. busy is always low, so
//   a new request may be issued every cycle.
//   Result: done is high for exactly one cycle with rsp (quotient,
//   remainder_magnitude, status) valid in that same cycle. Results leave in
//   request order. There is no back-pressure; the receiver must take each one.
// Pipeline
//   From start to done, a request passes one register for operand magnitudes,
//   one per slice of quotient bits (each slice is a chain of BITS_PER_STAGE
//   compare/subtracts on the partial remainder) and one for the sign fix-up.
// Throughput
//   One request per cycle; every stage advances every cycle.
// Reset
//   arst_n clears all stage valid bits at once; requests in flight are dropped
//   and no done pulse follows. Data registers are not reset.
// Status
//   STATUS_DIV_ZERO: quotient 0, remainder = |dividend| (saturated).
//   STATUS_OVERFLOW: most negative / -1, quotient saturated to max positive.
module signed_shift_subtract_divider_unit #(
	parameter int BITS_PER_STAGE = ssd_pkg::DIV_BITS_PER_STAGE
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  ssd_pkg::ssd_req_t  req,
	output logic               done,
	output ssd_pkg::ssd_rsp_t  rsp
);
	import ssd_pkg::*;

	localparam int NUM_STAGES = (DATA_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

	// pipeline never stalls: the receiver has no way to hold results
	assign busy = 1'b0;

	logic      stage_valid [NUM_STAGES+1];
	ssd_work_t stage_data  [NUM_STAGES+1];

	ssd_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.req      (req),
		.valid_s1 (stage_valid[0]),
		.data_s1  (stage_data[0])
	);

	// slice k handles quotient bits from FIRST down, MSB first; last slice may be short
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
		localparam int FIRST = DATA_WIDTH - 1 - k * BITS_PER_STAGE;
		localparam int NBITS = (FIRST + 1 < BITS_PER_STAGE) ? FIRST + 1 : BITS_PER_STAGE;

		ssd_step #(
			.FIRST_BIT  (FIRST),
			.STAGE_BITS (NBITS)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stage_valid[k]),
			.in_data  (stage_data[k]),
			.valid_s1 (stage_valid[k+1]),
			.data_s1  (stage_data[k+1])
		);
	end

	ssd_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stage_valid[NUM_STAGES]),
		.in_data  (stage_data[NUM_STAGES]),
		.valid_s1 (done),
		.rsp_s1   (rsp)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb_signed_shift_subtract_divider_unit.sv
// Testbench for the signed divider: queued request driver, result monitor, predictor.
`timescale 1ns / 1ps
module tb_signed_shift_subtract_divider_unit;
	import ssd_pkg::*;

	localparam int W = DATA_WIDTH;
	// start to done: through prep, one step stage per quotient bit, and post
	localparam int LATENCY = 2 + W;
	// cycles with neither a request nor a result taken before giving up
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PER_PHASE = 282;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ssd_req_t req;
	logic     done;
	ssd_rsp_t rsp;

	signed_shift_subtract_divider_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	ssd_req_t pending_requests[$];
	ssd_rsp_t expected_results[$];
	int       sender_idle_pct = 0;
	int       error_count = 0;
	int       requests_taken = 0;
	int       results_checked = 0;
	int       div_zero_seen = 0;
	int       overflow_seen = 0;
	int       quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Magnitude-based restoring division, one quotient bit per step, MSB first.
	// The quotient takes the sign of a ^ b, so it truncates toward zero; the
	// remainder stays a magnitude.
	function automatic ssd_rsp_t divide_signed(logic [W-1:0] a, logic [W-1:0] b);
		logic [W-1:0] amag;
		logic [W-1:0] bmag;
		logic [W-1:0] quo;
		logic [W:0]   part;
		logic         negative;
		ssd_rsp_t     res;
		// negating the most negative value leaves 2^(W-1), which is its exact magnitude
		amag = a[W-1] ? -a : a;
		bmag = b[W-1] ? -b : b;
		negative = a[W-1] ^ b[W-1];
		res = '0;
		if (bmag == '0) begin
			// divide by zero: remainder carries |dividend|, clipped to the field
			res.quotient = '0;
			res.remainder_magnitude = amag[W-1] ? '1 : amag[W-2:0];
			res.status = STATUS_DIV_ZERO;
			return res;
		end
		quo = '0;
		part = '0;
		for (int i = W - 1; i >= 0; i--) begin
			part = {part[W-1:0], amag[i]};
			if (part >= {1'b0, bmag}) begin
				part = part - {1'b0, bmag};
				quo[i] = 1'b1;
			end
		end
		res.status = STATUS_OK;
		if (!negative && quo[W-1]) begin
			// only min / -1 gets here: clip to the largest positive quotient
			quo = {1'b0, {(W-1){1'b1}}};
			res.status = STATUS_OVERFLOW;
		end else if (negative) begin
			quo = -quo;
		end
		res.quotient = quo;
		res.remainder_magnitude = part[W-2:0];
		return res;
	endfunction

	function automatic logic [W-1:0] rand_word();
		return W'({$urandom, $urandom});
	endfunction

	function automatic logic [W-1:0] rand_small(int span);
		return W'($urandom_range(2 * span)) - W'(span);
	endfunction

	// Operand mix: full-range words, plus small values, zero divisors, extremes
	// and operands shifted down by a random amount so quotients of every size appear.
	function automatic ssd_req_t random_request();
		ssd_req_t     r;
		logic [W-1:0] extremes[4];
		extremes[0] = {1'b1, {(W-1){1'b0}}};
		extremes[1] = {1'b0, {(W-1){1'b1}}};
		extremes[2] = '1;
		extremes[3] = W'(1);
		r.dividend = rand_word();
		r.divisor = rand_word();
		case ($urandom_range(11))
			4: begin
				r.dividend = rand_small(300);
				r.divisor = rand_small(20);
			end
			5: r.divisor = rand_small(16);
			6: r.divisor = '0;
			7: r.dividend = extremes[$urandom_range(3)];
			8: begin
				r.dividend = extremes[$urandom_range(1)];
				r.divisor = extremes[$urandom_range(3)];
			end
			9: r.dividend = $signed(r.dividend) >>> $urandom_range(W - 1);
			10: r.divisor = $signed(r.divisor) >>> $urandom_range(W - 1);
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_request(logic [W-1:0] a, logic [W-1:0] b);
		ssd_req_t r;
		r.dividend = a;
		r.divisor = b;
		pending_requests.push_back(r);
	endtask

	// Driver: a request is taken at an edge with start high and busy low; the
	// next one goes out at that same edge unless the sender idles this cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(divide_signed(req.dividend, req.divisor));
				requests_taken++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					req <= pending_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done marks a one-cycle result; it is matched against the oldest
	// outstanding request.
	always @(posedge clk) begin
		ssd_rsp_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: quotient %0d", rsp.quotient);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.status == STATUS_DIV_ZERO) div_zero_seen++;
				if (want.status == STATUS_OVERFLOW) overflow_seen++;
				if (rsp.quotient !== want.quotient) begin
					$error("quotient: expected %0d, got %0d", want.quotient, rsp.quotient);
					error_count++;
				end
				if (rsp.remainder_magnitude !== want.remainder_magnitude) begin
					$error("remainder_magnitude: expected %0d, got %0d",
						want.remainder_magnitude, rsp.remainder_magnitude);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles where nothing moves in either direction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("timeout: %0d cycles without a request or result", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [W-1:0] min_val;
		logic [W-1:0] max_val;
		int           idle_plan[4];
		min_val = {1'b1, {(W-1){1'b0}}};
		max_val = {1'b0, {(W-1){1'b1}}};
		idle_plan[0] = 0;
		idle_plan[1] = 62;
		idle_plan[2] = 27;
		idle_plan[3] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sign combinations, extremes, divide by zero, min / -1,
		// most negative divisor
		queue_request(W'(0), W'(1));
		queue_request(W'(1), W'(1));
		queue_request(W'(7), W'(2));
		queue_request(-W'(7), W'(2));
		queue_request(W'(7), -W'(2));
		queue_request(-W'(7), -W'(2));
		queue_request(W'(1), W'(3));
		queue_request(max_val, W'(1));
		queue_request(min_val, W'(1));
		queue_request(max_val, '1);
		queue_request(min_val, '1);
		queue_request(min_val, W'(2));
		queue_request(min_val, min_val);
		queue_request(max_val, min_val);
		queue_request(W'(1), min_val);
		queue_request(min_val, max_val);
		queue_request(max_val, max_val);
		queue_request('1, '1);
		queue_request(W'(12345678), -W'(1000));
		queue_request(W'(5), '0);
		queue_request(-W'(5), '0);
		queue_request(min_val, '0);
		queue_request(max_val, '0);
		queue_request('0, '0);
		while (pending_requests.size() != 0) @(posedge clk);

		foreach (idle_plan[p]) begin
			sender_idle_pct = idle_plan[p];
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_requests.push_back(random_request());
			while (pending_requests.size() != 0) @(posedge clk);
		end

		// drain: everything sent must come back, then watch for stray results
		while (start || expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);

		$display("covered %0d requests, %0d results checked (%0d divide by zero, %0d overflow)",
			requests_taken, results_checked, div_zero_seen, overflow_seen);
		$display("sender idle phases 0/62/27/0 percent; %0d mismatches", error_count);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: signed_shift_subtract_divider_unit.f
src/ssd_pkg.sv
src/ssd_prep.sv
src/ssd_step.sv
src/ssd_post.sv
src/signed_shift_subtract_divider_unit.sv
tb/sv/tb_signed_shift_subtract_divider_unit.sv
